@@ hdl/grct_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the glyph range coverage table.
// Used by grct_mem, grct_ctrl and the top level; depends on nothing.
package grct_pkg;

  localparam int MAX_RANGES_DEF = 64;
  localparam int GW = 16;
  localparam int HW = 7;

  localparam logic [2:0] CMD_CLEAR      = 3'd0;
  localparam logic [2:0] CMD_LOAD       = 3'd1;
  localparam logic [2:0] CMD_INSERT     = 3'd2;
  localparam logic [2:0] CMD_FIND_GLYPH = 3'd3;
  localparam logic [2:0] CMD_FIND_INDEX = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_COVERED   = 2'd3;

  typedef struct packed {
    logic [GW-1:0] lo;
    logic [GW-1:0] hi;
    logic [GW-1:0] first;
  } rec_t;

  typedef struct packed {
    logic [1:0]    status;
    logic [GW-1:0] index;
    logic [GW-1:0] glyph;
    logic [HW-1:0] held;
  } res_t;

endpackage

@@ hdl/grct_mem.sv @@
`timescale 1ns / 1ps
// Range record store: one write port, one read port, registered read data.
// Depends on grct_pkg for the record type.
module grct_mem #(
  parameter int MAX_RANGES = grct_pkg::MAX_RANGES_DEF,
  parameter int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  grct_pkg::rec_t     wr_data,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output grct_pkg::rec_t     rd_data
);
  import grct_pkg::*;

  rec_t mem [MAX_RANGES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/grct_ctrl.sv @@
`timescale 1ns / 1ps
// Command sequencer: table scans for lookups and duplicate checks, and the
// streaming rebuild that inserts, merges and renumbers. Depends on grct_pkg.
module grct_ctrl #(
  parameter int MAX_RANGES = grct_pkg::MAX_RANGES_DEF,
  parameter int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1,
  parameter int CW = $clog2(MAX_RANGES + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [2:0]              in_cmd,
  input  logic [grct_pkg::GW-1:0] in_glyph_id,
  input  logic [grct_pkg::GW-1:0] in_end_glyph,
  input  logic [grct_pkg::GW-1:0] in_coverage_index,
  output logic                    mem_wr_en,
  output logic [AW-1:0]           mem_wr_addr,
  output grct_pkg::rec_t          mem_wr_data,
  output logic                    mem_rd_en,
  output logic [AW-1:0]           mem_rd_addr,
  input  grct_pkg::rec_t          mem_rd_data,
  output logic                    res_vld,
  output grct_pkg::res_t          res,
  input  logic                    res_take
);
  import grct_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_RISSUE = 6'b000100,
    S_RDATA  = 6'b001000,
    S_RTAIL  = 6'b010000,
    S_FIN    = 6'b100000
  } state_t;

  state_t        state_r, state_nxt;
  logic [2:0]    cmd_r, cmd_nxt;
  logic [GW-1:0] glyph_r, glyph_nxt, cidx_r, cidx_nxt;
  logic [CW-1:0] total_r, total_nxt, i_r, i_nxt, w_r, w_nxt;
  logic          rv_r, rv_nxt, found_r, found_nxt, pv_r, pv_nxt, ins_r, ins_nxt;
  rec_t          p_r, p_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [GW-1:0] idx_r, idx_nxt, gly_r, gly_nxt;
  logic          inc_vld;
  rec_t          inc;
  rec_t          new_rec;
  logic          more;

  assign new_rec = '{lo: glyph_r, hi: glyph_r, first: '0};
  assign more    = (i_r < total_r);

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    glyph_nxt   = glyph_r;
    cidx_nxt    = cidx_r;
    total_nxt   = total_r;
    i_nxt       = i_r;
    w_nxt       = w_r;
    rv_nxt      = rv_r;
    found_nxt   = found_r;
    pv_nxt      = pv_r;
    ins_nxt     = ins_r;
    p_nxt       = p_r;
    status_nxt  = status_r;
    idx_nxt     = idx_r;
    gly_nxt     = gly_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = '0;
    mem_wr_data = p_r;
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;
    inc_vld     = 1'b0;
    inc         = new_rec;
    res_vld     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_cmd;
          glyph_nxt  = in_glyph_id;
          cidx_nxt   = in_coverage_index;
          i_nxt      = '0;
          rv_nxt     = 1'b0;
          found_nxt  = 1'b0;
          idx_nxt    = '0;
          gly_nxt    = '0;
          status_nxt = ST_OK;
          state_nxt  = S_FIN;
          if (in_cmd == CMD_CLEAR) begin
            total_nxt = '0;
          end else if (in_cmd == CMD_LOAD) begin
            if (total_r == CW'(MAX_RANGES)) begin
              status_nxt = ST_FULL;
            end else begin
              mem_wr_en   = 1'b1;
              mem_wr_addr = total_r[AW-1:0];
              mem_wr_data = '{lo: in_glyph_id, hi: in_end_glyph, first: in_coverage_index};
              total_nxt   = total_r + CW'(1);
            end
          end else if (in_cmd == CMD_INSERT || in_cmd == CMD_FIND_GLYPH ||
                       in_cmd == CMD_FIND_INDEX) begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // One read per cycle; the data of the previous read is checked here.
        if (more) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = i_r[AW-1:0];
          i_nxt       = i_r + CW'(1);
        end
        rv_nxt = more;
        if (rv_r) begin
          if (cmd_r == CMD_FIND_INDEX) begin
            if (mem_rd_data.hi >= mem_rd_data.lo && cidx_r >= mem_rd_data.first &&
                (cidx_r - mem_rd_data.first) <= (mem_rd_data.hi - mem_rd_data.lo)) begin
              found_nxt = 1'b1;
              gly_nxt   = mem_rd_data.lo + cidx_r - mem_rd_data.first;
            end
          end else if (glyph_r >= mem_rd_data.lo && glyph_r <= mem_rd_data.hi) begin
            found_nxt = 1'b1;
            idx_nxt   = glyph_r - mem_rd_data.lo + mem_rd_data.first;
          end
        end
        if (!more && !rv_r) begin
          state_nxt = S_FIN;
          if (cmd_r == CMD_INSERT) begin
            idx_nxt = '0;
            if (found_r) begin
              status_nxt = ST_COVERED;
            end else if (total_r == CW'(MAX_RANGES)) begin
              status_nxt = ST_FULL;
            end else begin
              i_nxt     = '0;
              w_nxt     = '0;
              pv_nxt    = 1'b0;
              ins_nxt   = 1'b0;
              state_nxt = S_RISSUE;
            end
          end else begin
            status_nxt = found_r ? ST_OK : ST_NOT_FOUND;
          end
        end
      end
      S_RISSUE: begin
        if (more) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = i_r[AW-1:0];
          state_nxt   = S_RDATA;
        end else begin
          state_nxt = S_RTAIL;
        end
      end
      S_RDATA: begin
        inc_vld = 1'b1;
        if (!ins_r && glyph_r < mem_rd_data.lo) begin
          ins_nxt = 1'b1;
        end else begin
          inc       = mem_rd_data;
          i_nxt     = i_r + CW'(1);
          state_nxt = S_RISSUE;
        end
      end
      S_RTAIL: begin
        if (!ins_r) begin
          inc_vld = 1'b1;
          ins_nxt = 1'b1;
        end else begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = w_r[AW-1:0];
          mem_wr_data = p_r;
          total_nxt   = w_r + CW'(1);
          status_nxt  = ST_OK;
          state_nxt   = S_FIN;
        end
      end
      S_FIN: begin
        res_vld = 1'b1;
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Pending record: take the incoming one when none is pending, merge it when
    // adjacent, or else retire the pending one with its renumbered successor taking its place.
    if (inc_vld) begin
      if (!pv_r) begin
        pv_nxt = 1'b1;
        p_nxt  = '{lo: inc.lo, hi: inc.hi, first: '0};
      end else if (({1'b0, p_r.hi} + 17'd1) == {1'b0, inc.lo}) begin
        p_nxt.hi = inc.hi;
      end else begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = w_r[AW-1:0];
        mem_wr_data = p_r;
        w_nxt       = w_r + CW'(1);
        p_nxt       = '{lo: inc.lo, hi: inc.hi,
                        first: p_r.first + (p_r.hi - p_r.lo + GW'(1))};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      total_r <= '0;
      rv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      rv_r    <= rv_nxt;
    end
    cmd_r    <= cmd_nxt;
    glyph_r  <= glyph_nxt;
    cidx_r   <= cidx_nxt;
    i_r      <= i_nxt;
    w_r      <= w_nxt;
    found_r  <= found_nxt;
    pv_r     <= pv_nxt;
    ins_r    <= ins_nxt;
    p_r      <= p_nxt;
    status_r <= status_nxt;
    idx_r    <= idx_nxt;
    gly_r    <= gly_nxt;
  end

  assign in_stall = (state_r != S_IDLE);
  assign res = '{status: status_r, index: idx_r, glyph: gly_r, held: HW'(total_r)};

endmodule

@@ hdl/glyph_range_coverage_table_core.sv @@
`timescale 1ns / 1ps
// Top level of the glyph range coverage table: record store, sequencer and
// output word register. Depends on grct_pkg, grct_mem and grct_ctrl.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  cmd, glyph_id, end_glyph, coverage_index
//   out_     output     out_valid / out_stall status, index_out, glyph_out, ranges_held
//
// Clear, load and unused codes go from idle straight to the result word.
// Lookups scan all N stored ranges, one read per cycle of the record memory.
// Insert also scans, then adds a rebuild pass over the records (read, then
// merge and write back) that inserts the new range and renumbers.
// Reset is synchronous and active low; it empties the table, and the record
// memory itself needs no clearing. A stalled output word holds; the next input
// word is accepted while the finished one waits in the output register.
module glyph_range_coverage_table_core #(
  parameter int MAX_RANGES = grct_pkg::MAX_RANGES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [2:0]              in_cmd,
  input  logic [grct_pkg::GW-1:0] in_glyph_id,
  input  logic [grct_pkg::GW-1:0] in_end_glyph,
  input  logic [grct_pkg::GW-1:0] in_coverage_index,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_status,
  output logic [grct_pkg::GW-1:0] out_index_out,
  output logic [grct_pkg::GW-1:0] out_glyph_out,
  output logic [grct_pkg::HW-1:0] out_ranges_held
);
  import grct_pkg::*;

  localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CW = $clog2(MAX_RANGES + 1);

  logic          mem_wr_en, mem_rd_en;
  logic [AW-1:0] mem_wr_addr, mem_rd_addr;
  rec_t          mem_wr_data, mem_rd_data;
  logic          res_vld, res_take;
  res_t          res;
  logic          out_valid_r;
  res_t          out_r;

  grct_mem #(.MAX_RANGES(MAX_RANGES), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  grct_ctrl #(.MAX_RANGES(MAX_RANGES), .AW(AW), .CW(CW)) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_glyph_id       (in_glyph_id),
    .in_end_glyph      (in_end_glyph),
    .in_coverage_index (in_coverage_index),
    .mem_wr_en         (mem_wr_en),
    .mem_wr_addr       (mem_wr_addr),
    .mem_wr_data       (mem_wr_data),
    .mem_rd_en         (mem_rd_en),
    .mem_rd_addr       (mem_rd_addr),
    .mem_rd_data       (mem_rd_data),
    .res_vld           (res_vld),
    .res               (res),
    .res_take          (res_take)
  );

  // The finished word moves into the output register when it is empty or
  // being taken in this same cycle.
  assign res_take = res_vld && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_r.status;
  assign out_index_out   = out_r.index;
  assign out_glyph_out   = out_r.glyph;
  assign out_ranges_held = out_r.held;

endmodule
